[sv/record_exchange_sorter_with_totals_macros.svh]
// ----------------------------------------------------------------------------
// record exchange sorter assertion macros
// shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef RECORD_EXCHANGE_SORTER_WITH_TOTALS_MACROS_SVH
`define RECORD_EXCHANGE_SORTER_WITH_TOTALS_MACROS_SVH

// same-cycle implication, idle during reset
`define RXS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rxs same-cycle check failed");

// next-cycle implication, idle during reset
`define RXS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rxs next-cycle check failed");

`endif

[sv/rxs_pkg.sv]
// ----------------------------------------------------------------------------
// rxs_pkg
// record layout, field widths and controller/datapath command types
// ----------------------------------------------------------------------------
package rxs_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned AMT_W   = 31;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned KEY_W   = YEAR_W + MONTH_W + DAY_W;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [AMT_W-1:0]   amount;
    logic               is_credit;
  } record_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take the input beat into the store
    logic fetch;  // read slot i
    logic first;  // latch slot i, read slot i+1
    logic scan;   // compare and exchange against slot j
    logic emit;   // slot i is final, drive it out
    logic done;   // last beat of the batch, clear the batch state
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic i_last; // i is the last stored slot
    logic j_last; // j is the last stored slot
  } dp_status_t;

  function automatic logic [KEY_W-1:0] date_key(input record_t r);
    date_key = {r.year, r.month, r.day};
  endfunction

endpackage

[sv/rxs_ctrl.sv]
// ----------------------------------------------------------------------------
// rxs_ctrl
// sequencer for load, sort passes and emit
// ----------------------------------------------------------------------------
module rxs_ctrl
  import rxs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       last_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_FIRST = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_i) state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_FIRST;
      end
      ST_FIRST: begin
        cmd_o.first = 1'b1;
        if (status_i.i_last) begin
          cmd_o.emit = 1'b1;
          cmd_o.done = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.j_last) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[sv/rxs_datapath.sv]
// ----------------------------------------------------------------------------
// rxs_datapath
// record store, running sums, pass counters, compare and output register
// ----------------------------------------------------------------------------
module rxs_datapath
  import rxs_pkg::*;
#(
  parameter int unsigned RECORDS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  record_t            rec_i,
  output record_t            rec_o,
  output logic               strobe_o,
  output logic               end_of_run_o,
  output logic [SUM_W-1:0]   total_credits_o,
  output logic [SUM_W-1:0]   total_debits_o,
  output logic [SUM_W-1:0]   total_amount_o,
  output logic               dropped_o
);

  localparam int unsigned IDX_W = $clog2(RECORDS);
  localparam int unsigned CNT_W = $clog2(RECORDS + 1);

  record_t mem [RECORDS];

  logic [CNT_W-1:0] count_q;
  logic [SUM_W-1:0] credit_q, debit_q;
  logic             ovf_q;
  logic [IDX_W-1:0] i_q, j_q;
  record_t          cur_q, cur_d, rd_q;

  logic             full, greater;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  record_t          wr_data;
  logic [SUM_W-1:0] amt_ext;

  assign full    = (count_q == CNT_W'(RECORDS));
  assign greater = (date_key(cur_q) > date_key(rd_q));
  assign amt_ext = SUM_W'(rec_i.amount);

  assign status_o.i_last = ((CNT_W'(i_q) + CNT_W'(1)) == count_q);
  assign status_o.j_last = ((CNT_W'(j_q) + CNT_W'(1)) == count_q);

  // single write port: load appends, scan parks the larger record at slot j
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IDX_W-1:0];
    wr_data = rec_i;
    if (cmd_i.load && !full) begin
      wr_en = 1'b1;
    end else if (cmd_i.scan && greater) begin
      wr_en   = 1'b1;
      wr_addr = j_q;
      wr_data = cur_q;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i_q;
    if (cmd_i.fetch) begin
      rd_en = 1'b1;
    end else if (cmd_i.first) begin
      rd_en   = !status_o.i_last;
      rd_addr = i_q + IDX_W'(1);
    end else if (cmd_i.scan) begin
      rd_en   = !status_o.j_last;
      rd_addr = j_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // record held for slot i during its pass
  always_comb begin
    cur_d = cur_q;
    if (cmd_i.first) begin
      cur_d = rd_q;
    end else if (cmd_i.scan && greater) begin
      cur_d = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      credit_q <= '0;
      debit_q  <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
          if (rec_i.is_credit) credit_q <= credit_q + amt_ext;
          else                 debit_q  <= debit_q + amt_ext;
        end
      end
      if (cmd_i.first) j_q <= i_q + IDX_W'(1);
      if (cmd_i.scan)  j_q <= j_q + IDX_W'(1);
      if (cmd_i.emit)  i_q <= i_q + IDX_W'(1);
      if (cmd_i.done) begin
        count_q  <= '0;
        credit_q <= '0;
        debit_q  <= '0;
        ovf_q    <= 1'b0;
        i_q      <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rec_o           <= cur_d;
      end_of_run_o    <= status_o.i_last;
      total_credits_o <= credit_q;
      total_debits_o  <= debit_q;
      total_amount_o  <= credit_q + debit_q;
      dropped_o       <= ovf_q;
    end
  end

endmodule

[sv/record_exchange_sorter_with_totals.sv]
// ----------------------------------------------------------------------------
// record_exchange_sorter_with_totals
// collects dated records, sorts them by date and emits them with batch totals
// ----------------------------------------------------------------------------
// after the last beat the sequencer fetches slot i, latches it and scans the
//   later slots, if any; each result is registered at the end of its pass
// the sort makes one compare per cycle while scanning, through the single
//   read port of the record store; no beat is taken while a batch is sorted
// results come with at least a fetch state between them; the receiver cannot stall them
// reset: asynchronous, clears controller, count, sums and drop flag; the
//   store contents are left as they are
// ----------------------------------------------------------------------------
module record_exchange_sorter_with_totals
  import rxs_pkg::*;
#(
  parameter int unsigned RECORDS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input beat: taken when start is high and busy is low
  input  logic                 start,
  output logic                 busy,
  input  logic [DAY_W-1:0]     day_i,
  input  logic [MONTH_W-1:0]   month_i,
  input  logic [YEAR_W-1:0]    year_i,
  input  logic [AMT_W-1:0]     amount_cents_i,
  input  logic                 is_credit_i,
  input  logic                 last_i,
  // result beat: valid for exactly the cycle strobe is high
  output logic                 strobe,
  output logic [DAY_W-1:0]     out_day_o,
  output logic [MONTH_W-1:0]   out_month_o,
  output logic [YEAR_W-1:0]    out_year_o,
  output logic [AMT_W-1:0]     out_amount_cents_o,
  output logic                 out_is_credit_o,
  output logic                 end_of_run_o,
  output logic [SUM_W-1:0]     total_credits_o,
  output logic [SUM_W-1:0]     total_debits_o,
  output logic [SUM_W-1:0]     total_amount_o,
  output logic                 dropped_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  record_t    rec_in, rec_out;

  // pack the incoming beat into one store word
  assign rec_in.day       = day_i;
  assign rec_in.month     = month_i;
  assign rec_in.year      = year_i;
  assign rec_in.amount    = amount_cents_i;
  assign rec_in.is_credit = is_credit_i;

  // sequencer: idle/load, then per pass fetch slot i, latch it, scan j > i
  rxs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .last_i   (last_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // store, sums and compare; slot i is final at the end of its pass and
  // goes straight to the output register
  rxs_datapath #(
    .RECORDS (RECORDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .rec_i           (rec_in),
    .rec_o           (rec_out),
    .strobe_o        (strobe),
    .end_of_run_o    (end_of_run_o),
    .total_credits_o (total_credits_o),
    .total_debits_o  (total_debits_o),
    .total_amount_o  (total_amount_o),
    .dropped_o       (dropped_o)
  );

  // unpack the emitted record
  assign out_day_o          = rec_out.day;
  assign out_month_o        = rec_out.month;
  assign out_year_o         = rec_out.year;
  assign out_amount_cents_o = rec_out.amount;
  assign out_is_credit_o    = rec_out.is_credit;

endmodule

[sv/rxs_checker.sv]
// ----------------------------------------------------------------------------
// rxs_checker
// port-level checks on batch sequencing, bound to the top level
// ----------------------------------------------------------------------------
`include "record_exchange_sorter_with_totals_macros.svh"

module rxs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_i,
  input logic strobe,
  input logic end_of_run_o
);

  // a batch-ending beat starts the sort at once
  `RXS_ASSERT_NEXT(a_last_starts_sort, clk_i, rst_ni, start && !busy && last_i, busy)

  // a plain record beat never produces a result
  `RXS_ASSERT_NEXT(a_load_no_result, clk_i, rst_ni, start && !busy && !last_i, !strobe)

  // more results follow while not at end of run
  `RXS_ASSERT_NOW(a_mid_run_busy, clk_i, rst_ni, strobe && !end_of_run_o, busy)

  // the final result of a batch finds the block ready again
  `RXS_ASSERT_NOW(a_end_run_idle, clk_i, rst_ni, strobe && end_of_run_o, !busy)

endmodule

bind record_exchange_sorter_with_totals rxs_checker u_rxs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .last_i       (last_i),
  .strobe       (strobe),
  .end_of_run_o (end_of_run_o)
);

[tb/sv/record_sorter_checker.sv]
// ----------------------------------------------------------------------------
// record_sorter_checker
// watches the record and result channels, predicts the sorted batch output
// and compares every result beat field by field
// ----------------------------------------------------------------------------
module record_sorter_checker
  import rxs_pkg::*;
#(
  parameter int unsigned RECORDS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // record channel
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [DAY_W-1:0]   day_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [AMT_W-1:0]   amount_cents_i,
  input  logic               is_credit_i,
  input  logic               last_i,
  // result channel
  input  logic               strobe_i,
  input  logic [DAY_W-1:0]   out_day_i,
  input  logic [MONTH_W-1:0] out_month_i,
  input  logic [YEAR_W-1:0]  out_year_i,
  input  logic [AMT_W-1:0]   out_amount_cents_i,
  input  logic               out_is_credit_i,
  input  logic               end_of_run_i,
  input  logic [SUM_W-1:0]   total_credits_i,
  input  logic [SUM_W-1:0]   total_debits_i,
  input  logic [SUM_W-1:0]   total_amount_i,
  input  logic               dropped_i,
  // to the testbench top
  output int                 err_count_o,
  output int                 pending_o
);

  typedef struct {
    record_t          rec;
    logic             end_of_run;
    logic [SUM_W-1:0] credits;
    logic [SUM_W-1:0] debits;
    logic [SUM_W-1:0] total;
    logic             dropped;
  } sorted_beat_t;

  record_t          batch_slots [RECORDS];
  int unsigned      batch_len;
  logic [SUM_W-1:0] credit_sum;
  logic [SUM_W-1:0] debit_sum;
  logic             overflow_seen;
  sorted_beat_t     sorted_q [$];
  int               errors = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // chronological order: year, then month, then day, all by raw bit value
  function automatic bit dated_after(input record_t a, input record_t b);
    return {a.year, a.month, a.day} > {b.year, b.month, b.day};
  endfunction

  // exchange sort of the batch, then one expected beat per stored record
  task automatic publish_batch();
    record_t      tmp;
    sorted_beat_t beat;
    for (int i = 0; i < int'(batch_len); i++) begin
      for (int j = i + 1; j < int'(batch_len); j++) begin
        if (dated_after(batch_slots[i], batch_slots[j])) begin
          tmp            = batch_slots[i];
          batch_slots[i] = batch_slots[j];
          batch_slots[j] = tmp;
        end
      end
    end
    for (int k = 0; k < int'(batch_len); k++) begin
      beat.rec        = batch_slots[k];
      beat.end_of_run = (k == int'(batch_len) - 1);
      beat.credits    = credit_sum;
      beat.debits     = debit_sum;
      beat.total      = credit_sum + debit_sum;
      beat.dropped    = overflow_seen;
      sorted_q.push_back(beat);
    end
    batch_len     = 0;
    credit_sum    = '0;
    debit_sum     = '0;
    overflow_seen = 1'b0;
  endtask

  task automatic take_record();
    record_t rec;
    rec.day       = day_i;
    rec.month     = month_i;
    rec.year      = year_i;
    rec.amount    = amount_cents_i;
    rec.is_credit = is_credit_i;
    if (batch_len < RECORDS) begin
      batch_slots[batch_len] = rec;
      batch_len++;
      if (rec.is_credit) credit_sum = credit_sum + SUM_W'(rec.amount);
      else debit_sum = debit_sum + SUM_W'(rec.amount);
    end else begin
      overflow_seen = 1'b1;
    end
    if (last_i) publish_batch();
  endtask

  task automatic check_result();
    sorted_beat_t want;
    if (sorted_q.size() == 0) begin
      report_mismatch("result beat with nothing expected");
    end else begin
      want = sorted_q.pop_front();
      check_field("out_day",          64'(out_day_i),          64'(want.rec.day));
      check_field("out_month",        64'(out_month_i),        64'(want.rec.month));
      check_field("out_year",         64'(out_year_i),         64'(want.rec.year));
      check_field("out_amount_cents", 64'(out_amount_cents_i), 64'(want.rec.amount));
      check_field("out_is_credit",    64'(out_is_credit_i),    64'(want.rec.is_credit));
      check_field("end_of_run",       64'(end_of_run_i),       64'(want.end_of_run));
      check_field("total_credits",    64'(total_credits_i),    64'(want.credits));
      check_field("total_debits",     64'(total_debits_i),     64'(want.debits));
      check_field("total_amount",     64'(total_amount_i),     64'(want.total));
      check_field("dropped",          64'(dropped_i),          64'(want.dropped));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_len     = 0;
      credit_sum    = '0;
      debit_sum     = '0;
      overflow_seen = 1'b0;
      sorted_q.delete();
      pending_o   <= 0;
      err_count_o <= 0;
    end else begin
      if (strobe_i) check_result();
      if (start_i && !busy_i) take_record();
      pending_o   <= sorted_q.size();
      err_count_o <= errors;
    end
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives batches of dated records into the sorter, directed corner batches
// first and then random batches, and gives the verdict from the checker
// ----------------------------------------------------------------------------
module tb_top;
  import rxs_pkg::*;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned ITEM_TARGET = 380;
  localparam logic [AMT_W-1:0] AMT_MAX = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;

  // record beat, all inputs known from time zero
  logic               start = 1'b0;
  logic               busy;
  logic [DAY_W-1:0]   day_i = '0;
  logic [MONTH_W-1:0] month_i = '0;
  logic [YEAR_W-1:0]  year_i = '0;
  logic [AMT_W-1:0]   amount_cents_i = '0;
  logic               is_credit_i = 1'b0;
  logic               last_i = 1'b0;

  // result beat
  logic               strobe;
  logic [DAY_W-1:0]   out_day_o;
  logic [MONTH_W-1:0] out_month_o;
  logic [YEAR_W-1:0]  out_year_o;
  logic [AMT_W-1:0]   out_amount_cents_o;
  logic               out_is_credit_o;
  logic               end_of_run_o;
  logic [SUM_W-1:0]   total_credits_o;
  logic [SUM_W-1:0]   total_debits_o;
  logic [SUM_W-1:0]   total_amount_o;
  logic               dropped_o;

  int                 err_count;
  int                 pending;

  // records handed over so far, and a per-batch switch for back-to-back beats
  int                 records_sent = 0;
  bit                 no_idle = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  record_exchange_sorter_with_totals #(
    .RECORDS(STORE_DEPTH)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .day_i              (day_i),
    .month_i            (month_i),
    .year_i             (year_i),
    .amount_cents_i     (amount_cents_i),
    .is_credit_i        (is_credit_i),
    .last_i             (last_i),
    .strobe             (strobe),
    .out_day_o          (out_day_o),
    .out_month_o        (out_month_o),
    .out_year_o         (out_year_o),
    .out_amount_cents_o (out_amount_cents_o),
    .out_is_credit_o    (out_is_credit_o),
    .end_of_run_o       (end_of_run_o),
    .total_credits_o    (total_credits_o),
    .total_debits_o     (total_debits_o),
    .total_amount_o     (total_amount_o),
    .dropped_o          (dropped_o)
  );

  record_sorter_checker #(
    .RECORDS(STORE_DEPTH)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .day_i              (day_i),
    .month_i            (month_i),
    .year_i             (year_i),
    .amount_cents_i     (amount_cents_i),
    .is_credit_i        (is_credit_i),
    .last_i             (last_i),
    .strobe_i           (strobe),
    .out_day_i          (out_day_o),
    .out_month_i        (out_month_o),
    .out_year_i         (out_year_o),
    .out_amount_cents_i (out_amount_cents_o),
    .out_is_credit_i    (out_is_credit_o),
    .end_of_run_i       (end_of_run_o),
    .total_credits_i    (total_credits_o),
    .total_debits_i     (total_debits_o),
    .total_amount_i     (total_amount_o),
    .dropped_i          (dropped_o),
    .err_count_o        (err_count),
    .pending_o          (pending)
  );

  function automatic record_t make_record(input int unsigned d, input int unsigned m,
                                          input int unsigned y, input logic [AMT_W-1:0] a,
                                          input bit c);
    record_t r;
    r.day       = DAY_W'(d);
    r.month     = MONTH_W'(m);
    r.year      = YEAR_W'(y);
    r.amount    = a;
    r.is_credit = c;
    return r;
  endfunction

  // idle gap before a beat: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle)   return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // random record; many land on a few neighboring dates of the batch so that
  // equal keys and near ties are common, some use raw bit patterns
  function automatic record_t random_record(input int unsigned base_year);
    record_t     r;
    int unsigned roll;
    int unsigned amt_roll;
    roll     = $urandom_range(0, 99);
    amt_roll = $urandom_range(0, 99);
    if (roll < 15) begin
      // out-of-range days and months, full-width years
      r.day   = DAY_W'($urandom_range(0, 31));
      r.month = MONTH_W'($urandom_range(0, 15));
      r.year  = YEAR_W'($urandom_range(0, 16383));
    end else if (roll < 55) begin
      r.day   = DAY_W'($urandom_range(1, 3));
      r.month = MONTH_W'($urandom_range(1, 3));
      r.year  = YEAR_W'(base_year + $urandom_range(0, 1));
    end else begin
      r.day   = DAY_W'($urandom_range(1, 31));
      r.month = MONTH_W'($urandom_range(1, 12));
      r.year  = YEAR_W'($urandom_range(0, 9999));
    end
    if (amt_roll < 10)      r.amount = '0;
    else if (amt_roll < 20) r.amount = AMT_MAX;
    else                    r.amount = AMT_W'($urandom);
    r.is_credit = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // one record beat; called at a rising edge, returns at the edge that takes it
  task automatic send_record(input record_t rec, input bit is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    day_i          <= rec.day;
    month_i        <= rec.month;
    year_i         <= rec.year;
    amount_cents_i <= rec.amount;
    is_credit_i    <= rec.is_credit;
    last_i         <= is_last;
    do @(posedge clk_i); while (busy);
    records_sent++;
  endtask

  initial begin
    int unsigned len;
    int unsigned base_year;
    int unsigned roll;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-record batch at the top of every in-range field
    send_record(make_record(31, 12, 9999, AMT_MAX, 1'b1), 1'b1);

    // field extremes, equal keys and out-of-range dates in one batch
    send_record(make_record(0, 0, 0, '0, 1'b0), 1'b0);
    send_record(make_record(31, 15, 16383, AMT_MAX, 1'b1), 1'b0);
    send_record(make_record(15, 6, 2024, 100, 1'b1), 1'b0);
    send_record(make_record(15, 6, 2024, 200, 1'b0), 1'b0);
    send_record(make_record(1, 13, 2024, 5, 1'b0), 1'b0);
    send_record(make_record(0, 6, 2024, 7, 1'b1), 1'b1);

    // reverse chronological with a tie in the middle, credits only
    send_record(make_record(20, 5, 9000, 11, 1'b1), 1'b0);
    send_record(make_record(3, 2, 8000, 22, 1'b1), 1'b0);
    send_record(make_record(3, 2, 8000, 33, 1'b1), 1'b0);
    send_record(make_record(9, 9, 7000, 44, 1'b1), 1'b0);
    send_record(make_record(2, 1, 100, AMT_MAX, 1'b1), 1'b0);
    send_record(make_record(1, 1, 1, 55, 1'b1), 1'b1);

    // all keys equal, debits only, back to back
    no_idle = 1'b1;
    send_record(make_record(1, 1, 2000, 1, 1'b0), 1'b0);
    send_record(make_record(1, 1, 2000, 2, 1'b0), 1'b0);
    send_record(make_record(1, 1, 2000, 3, 1'b0), 1'b0);
    send_record(make_record(1, 1, 2000, AMT_MAX, 1'b0), 1'b1);

    // random batches: mostly short, some long enough to fill and overflow
    // the store, including a last beat that arrives on a full store
    while (records_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 65)      len = $urandom_range(1, 8);
      else if (roll < 85) len = $urandom_range(9, STORE_DEPTH - 1);
      else                len = $urandom_range(STORE_DEPTH, STORE_DEPTH + 8);
      base_year = $urandom_range(0, 9998);
      no_idle   = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < int'(len); k++) begin
        send_record(random_record(base_year), k == int'(len) - 1);
      end
    end
    start <= 1'b0;

    // checker counts are registered, so they settle after the edge that takes the last beat
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // room for any stray result beat
    repeat (40) @(posedge clk_i);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
